[src/oli_pkg.sv]
// ----------------------------------------------------------------------------
// oli_pkg
// Shared constants for the ordered list block: command codes, data width and
// default capacity.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int DATA_W       = 32;
  localparam int CMD_W        = 2;
  localparam int CAPACITY_DEF = 32;

  // Any other command code deletes at a position.
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd2;

endpackage

[src/ordered_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Bounded ordered list in a circular store. Inserts at front or back, deletes
// at a position, then lists the whole list front to back.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  cmd     | in        | cmd_valid/cmd_ready  | command, operand
//  res     | out       | res_valid/res_ready  | element, is_last, list_empty,
//          |           |                      | insert_dropped
//
//  A delete at position p shifts the tail through the one-read, one-write
//  store. The listing then streams one element a cycle while res_ready is
//  high; the store's registered read is hidden by a read-ahead.
//  A new command is taken once the listing is issued, even while the last
//  result still waits in the output register. Reset clears count and front;
//  store contents stay as they were. res_ready low stalls the listing.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete #(
  parameter int CAPACITY = oli_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic [oli_pkg::CMD_W-1:0]         command,
  input  logic signed [oli_pkg::DATA_W-1:0] operand,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic signed [oli_pkg::DATA_W-1:0] element,
  output logic                              is_last,
  output logic                              list_empty,
  output logic                              insert_dropped
);
  import oli_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W:0]   CAP_EXT = (CNT_W+1)'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  typedef enum logic [1:0] {IDLE, SHIFT, LIST} state_t;

  state_t            state;
  logic [IDX_W-1:0]  front;
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [CNT_W-1:0]  rd_pos;    // shift: next list place to read
  logic              sh_pend;   // shift: read data waiting to be written
  logic [CNT_W-1:0]  sh_pos;    // shift: place the pending data goes to
  logic [CNT_W-1:0]  lp_rd;     // listing: reads issued
  logic              lp_pend;   // listing: read data not yet in output reg
  logic              lp_last;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;
  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] wdata;

  logic cmd_acc, is_ins, full, del_ok, out_free, lp_load, lp_issue, res_load;
  logic [IDX_W-1:0] front_dec;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] f,
                                            input logic [CNT_W-1:0] p);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(f) + (CNT_W+1)'(p);
    if (s >= CAP_EXT) s = s - CAP_EXT;
    return s[IDX_W-1:0];
  endfunction

  assign cmd_ready = (state == IDLE);
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign is_ins    = (command == CMD_INS_FRONT) || (command == CMD_INS_BACK);
  assign full      = (count == CNT_W'(CAPACITY));
  assign del_ok    = !operand[DATA_W-1] &&
                     ($unsigned(operand) < DATA_W'(count));
  assign front_dec = (front == '0) ? LAST_IDX : front - 1'b1;
  assign out_free  = !res_valid || res_ready;
  assign lp_load   = (state == LIST) && lp_pend && out_free;
  assign lp_issue  = (state == LIST) && (lp_rd < count) && (!lp_pend || lp_load);
  // output register takes a new result this cycle
  assign res_load  = (state == LIST) && ((count == '0) ? out_free : lp_load);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = operand;
    case (state)
      IDLE: begin
        if (cmd_acc && is_ins && !full) begin
          we    = 1'b1;
          waddr = (command == CMD_INS_FRONT) ? front_dec : slot(front, count);
        end
      end
      SHIFT: begin
        if (rd_pos < count) begin
          re    = 1'b1;
          raddr = slot(front, rd_pos);
        end
        if (sh_pend) begin
          we    = 1'b1;
          waddr = slot(front, sh_pos);
          wdata = rdata;
        end
      end
      LIST: begin
        if (lp_issue) begin
          re    = 1'b1;
          raddr = slot(front, lp_rd);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      front     <= '0;
      count     <= '0;
      dropped   <= 1'b0;
      rd_pos    <= '0;
      sh_pend   <= 1'b0;
      sh_pos    <= '0;
      lp_rd     <= '0;
      lp_pend   <= 1'b0;
      lp_last   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && !res_load) res_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (cmd_acc) begin
            lp_rd   <= '0;
            lp_pend <= 1'b0;
            dropped <= is_ins && full;
            state   <= (!is_ins && del_ok) ? SHIFT : LIST;
            if (is_ins) begin
              if (!full) begin
                count <= count + 1'b1;
                if (command == CMD_INS_FRONT) front <= front_dec;
              end
            end else if (del_ok) begin
              rd_pos  <= operand[CNT_W-1:0] + 1'b1;
              sh_pend <= 1'b0;
            end
          end
        end
        SHIFT: begin
          sh_pend <= re;
          if (re) begin
            sh_pos <= rd_pos - 1'b1;
            rd_pos <= rd_pos + 1'b1;
          end
          if (!re && !sh_pend) begin
            count <= count - 1'b1;
            state <= LIST;
          end
        end
        LIST: begin
          if (count == '0) begin
            if (out_free) begin
              res_valid      <= 1'b1;
              element        <= '0;
              is_last        <= 1'b1;
              list_empty     <= 1'b1;
              insert_dropped <= dropped;
              state          <= IDLE;
            end
          end else begin
            if (lp_load) begin
              res_valid      <= 1'b1;
              element        <= rdata;
              is_last        <= lp_last;
              list_empty     <= 1'b0;
              insert_dropped <= dropped;
            end
            if (lp_issue) begin
              lp_rd   <= lp_rd + 1'b1;
              lp_last <= (CNT_W'(lp_rd + 1'b1) == count);
              lp_pend <= 1'b1;
            end else if (lp_load) begin
              lp_pend <= 1'b0;
              if (lp_rd == count) state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
